// ===== rtl/core/batch_phased_task_dispatcher_assert.svh =====
// Assertion macros for the batch phased task dispatcher.
`ifndef BATCH_PHASED_TASK_DISPATCHER_ASSERT_SVH
`define BATCH_PHASED_TASK_DISPATCHER_ASSERT_SVH

`ifndef SYNTHESIS
`define BPTD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: invariant");
`define BPTD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
`define BPTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");
`else
`define BPTD_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define BPTD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BPTD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/bptd_pkg.sv =====
// Types, codes and helpers shared by the batch phased task dispatcher.
package bptd_pkg;

  localparam int unsigned LSUM_W = 22;
  localparam logic [LSUM_W-1:0] LSUM_MAX = {LSUM_W{1'b1}};
  localparam logic [15:0] COLLECT_TICKS_RESET = 16'd45;

  // Command codes
  localparam logic [2:0] CMD_SUBMIT    = 3'd0;
  localparam logic [2:0] CMD_TICK      = 3'd1;
  localparam logic [2:0] CMD_REQUEST   = 3'd2;
  localparam logic [2:0] CMD_DONE      = 3'd3;
  localparam logic [2:0] CMD_PAUSE     = 3'd4;
  localparam logic [2:0] CMD_RESUME    = 3'd5;
  localparam logic [2:0] CMD_TERMINATE = 3'd6;

  // Status codes
  localparam logic [3:0] ST_ACCEPTED       = 4'd0;
  localparam logic [3:0] ST_DECL_PAUSED    = 4'd1;
  localparam logic [3:0] ST_DECL_EXECUTING = 4'd2;
  localparam logic [3:0] ST_DECL_FULL      = 4'd3;
  localparam logic [3:0] ST_IGNORED        = 4'd4;
  localparam logic [3:0] ST_DISPATCHED     = 4'd5;
  localparam logic [3:0] ST_NO_TASK        = 4'd6;
  localparam logic [3:0] ST_WORKER_EXIT    = 4'd7;
  localparam logic [3:0] ST_DONE_ACK       = 4'd8;
  localparam logic [3:0] ST_PHASE_STARTED  = 4'd9;
  localparam logic [3:0] ST_PHASE_ENDED    = 4'd10;
  localparam logic [3:0] ST_TICK_ACK       = 4'd11;
  localparam logic [3:0] ST_CONTROL_ACK    = 4'd12;

  // Config register addresses (word index)
  localparam logic ADDR_COLLECT_TICKS = 1'b0;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] task_id;
    logic [7:0]  task_duration;
    logic        immediate;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        status;
    logic [15:0]       out_task_id;
    logic [7:0]        out_task_duration;
    logic [6:0]        queue_count;
    logic [2:0]        active_count;
    logic [15:0]       declined_total;
    logic [15:0]       completed_total;
    logic [15:0]       phase_total;
    logic [LSUM_W-1:0] queue_length_sum;
    logic              executing;
    logic              paused_flag;
    logic              terminated_flag;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } qop_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// ===== rtl/core/bptd_queue.sv =====
// Task FIFO: storage, head and tail pointers and fill count.
module bptd_queue #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned PTR_W       = $clog2(QUEUE_DEPTH),
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bptd_pkg::qop_t    qop_i,
  input  logic [23:0]       wdata_i,
  output logic [23:0]       head_data_o,
  output logic [CNT_W-1:0]  count_o,
  output logic [CNT_W-1:0]  count_next_o
);

  logic [23:0]      mem [QUEUE_DEPTH];
  logic [23:0]      rdata_q;
  logic [PTR_W-1:0] head_q, head_d, head_nx;
  logic [PTR_W-1:0] tail_q, tail_d, tail_nx;
  logic [PTR_W:0]   head_inc, tail_inc;
  logic [CNT_W-1:0] count_q, count_d;

  assign head_inc = {1'b0, head_q} + (PTR_W + 1)'(1);
  assign tail_inc = {1'b0, tail_q} + (PTR_W + 1)'(1);
  assign head_nx  = (head_inc >= (PTR_W + 1)'(QUEUE_DEPTH)) ? '0 : head_inc[PTR_W-1:0];
  assign tail_nx  = (tail_inc >= (PTR_W + 1)'(QUEUE_DEPTH)) ? '0 : tail_inc[PTR_W-1:0];

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (qop_i.flush) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end else if (qop_i.push) begin
      tail_d  = tail_nx;
      count_d = count_q + CNT_W'(1);
    end else if (qop_i.pop) begin
      head_d  = head_nx;
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // read follows the next head every cycle, so the head entry is ready in rdata_q
  always_ff @(posedge clk_i) begin
    if (qop_i.push && !qop_i.flush) begin
      mem[tail_q] <= wdata_i;
    end
    rdata_q <= mem[head_d];
  end

  assign head_data_o  = rdata_q;
  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

// ===== rtl/core/bptd_ctrl.sv =====
// Command decode, phase control, worker count and statistics counters.
module bptd_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned MAX_WORKERS = 4,
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1),
  parameter int unsigned BUSY_W      = $clog2(MAX_WORKERS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  bptd_pkg::in_item_t  item_i,
  input  logic [15:0]         collect_ticks_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [CNT_W-1:0]    count_next_i,
  input  logic [23:0]         head_data_i,
  output bptd_pkg::qop_t      qop_o,
  output logic [BUSY_W-1:0]   busy_o,
  output bptd_pkg::out_item_t result_o
);

  logic [BUSY_W-1:0]           busy_q, busy_d;
  logic [15:0]                 tick_q, tick_d, tick_inc;
  logic                        phase_q, phase_d;
  logic                        pause_q, pause_d;
  logic                        stop_q, stop_d;
  logic [15:0]                 decl_q, decl_d;
  logic [15:0]                 done_q, done_d;
  logic [15:0]                 phcnt_q, phcnt_d;
  logic [bptd_pkg::LSUM_W-1:0] lsum_q, lsum_d;
  logic [bptd_pkg::LSUM_W:0]   lsum_ext;
  logic                        q_empty, q_full, busy_free;
  logic [3:0]                  status;
  logic [15:0]                 oid;
  logic [7:0]                  odur;
  bptd_pkg::qop_t              qop;

  assign tick_inc  = tick_q + 16'd1;
  assign lsum_ext  = {1'b0, lsum_q} + (bptd_pkg::LSUM_W + 1)'(count_i);
  assign q_empty   = (count_i == '0);
  assign q_full    = (count_i >= CNT_W'(QUEUE_DEPTH));
  assign busy_free = (busy_q < BUSY_W'(MAX_WORKERS));

  always_comb begin
    busy_d  = busy_q;
    tick_d  = tick_q;
    phase_d = phase_q;
    pause_d = pause_q;
    stop_d  = stop_q;
    decl_d  = decl_q;
    done_d  = done_q;
    phcnt_d = phcnt_q;
    lsum_d  = lsum_q;
    qop     = '0;
    status  = bptd_pkg::ST_IGNORED;
    oid     = '0;
    odur    = '0;
    if (en_i) begin
      unique case (item_i.command)
        bptd_pkg::CMD_SUBMIT: begin
          if (stop_q) begin
            status = bptd_pkg::ST_IGNORED;
          end else if (pause_q) begin
            status = bptd_pkg::ST_DECL_PAUSED;
            decl_d = bptd_pkg::sat_inc16(decl_q);
          end else if (phase_q) begin
            status = bptd_pkg::ST_DECL_EXECUTING;
            decl_d = bptd_pkg::sat_inc16(decl_q);
          end else if (q_full) begin
            status = bptd_pkg::ST_DECL_FULL;
            decl_d = bptd_pkg::sat_inc16(decl_q);
          end else begin
            qop.push = 1'b1;
            status   = bptd_pkg::ST_ACCEPTED;
          end
        end
        bptd_pkg::CMD_TICK: begin
          if (stop_q) begin
            status = bptd_pkg::ST_IGNORED;
          end else if (phase_q || pause_q) begin
            status = bptd_pkg::ST_TICK_ACK;
          end else if (tick_inc >= collect_ticks_i) begin
            tick_d  = '0;
            phcnt_d = bptd_pkg::sat_inc16(phcnt_q);
            lsum_d  = (lsum_ext > (bptd_pkg::LSUM_W + 1)'(bptd_pkg::LSUM_MAX)) ?
                      bptd_pkg::LSUM_MAX : lsum_ext[bptd_pkg::LSUM_W-1:0];
            phase_d = !(q_empty && (busy_q == '0));
            status  = bptd_pkg::ST_PHASE_STARTED;
          end else begin
            tick_d = tick_inc;
            status = bptd_pkg::ST_TICK_ACK;
          end
        end
        bptd_pkg::CMD_REQUEST: begin
          if (stop_q && q_empty) begin
            status = bptd_pkg::ST_WORKER_EXIT;
          end else if (!q_empty && busy_free && (stop_q || (phase_q && !pause_q))) begin
            qop.pop = 1'b1;
            busy_d  = busy_q + BUSY_W'(1);
            oid     = head_data_i[23:8];
            odur    = head_data_i[7:0];
            status  = bptd_pkg::ST_DISPATCHED;
          end else begin
            status = bptd_pkg::ST_NO_TASK;
          end
        end
        bptd_pkg::CMD_DONE: begin
          if (busy_q == '0) begin
            status = bptd_pkg::ST_IGNORED;
          end else begin
            busy_d = busy_q - BUSY_W'(1);
            done_d = bptd_pkg::sat_inc16(done_q);
            if (!stop_q && phase_q && q_empty && (busy_d == '0)) begin
              phase_d = 1'b0;
              status  = bptd_pkg::ST_PHASE_ENDED;
            end else begin
              status = bptd_pkg::ST_DONE_ACK;
            end
          end
        end
        bptd_pkg::CMD_PAUSE: begin
          pause_d = 1'b1;
          status  = bptd_pkg::ST_CONTROL_ACK;
        end
        bptd_pkg::CMD_RESUME: begin
          pause_d = 1'b0;
          status  = bptd_pkg::ST_CONTROL_ACK;
        end
        bptd_pkg::CMD_TERMINATE: begin
          if (stop_q) begin
            status = bptd_pkg::ST_IGNORED;
          end else begin
            stop_d    = 1'b1;
            qop.flush = item_i.immediate;
            status    = bptd_pkg::ST_CONTROL_ACK;
          end
        end
        default: begin
          status = bptd_pkg::ST_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= '0;
      tick_q  <= '0;
      phase_q <= 1'b0;
      pause_q <= 1'b0;
      stop_q  <= 1'b0;
      decl_q  <= '0;
      done_q  <= '0;
      phcnt_q <= '0;
      lsum_q  <= '0;
    end else begin
      busy_q  <= busy_d;
      tick_q  <= tick_d;
      phase_q <= phase_d;
      pause_q <= pause_d;
      stop_q  <= stop_d;
      decl_q  <= decl_d;
      done_q  <= done_d;
      phcnt_q <= phcnt_d;
      lsum_q  <= lsum_d;
    end
  end

  always_comb begin
    result_o.status            = status;
    result_o.out_task_id       = oid;
    result_o.out_task_duration = odur;
    result_o.queue_count       = 7'(count_next_i);
    result_o.active_count      = 3'(busy_d);
    result_o.declined_total    = decl_d;
    result_o.completed_total   = done_d;
    result_o.phase_total       = phcnt_d;
    result_o.queue_length_sum  = lsum_d;
    result_o.executing         = phase_d;
    result_o.paused_flag       = pause_d;
    result_o.terminated_flag   = stop_d;
  end

  assign qop_o  = qop;
  assign busy_o = busy_q;

endmodule

// ===== rtl/core/batch_phased_task_dispatcher.sv =====
// Top level of the batch phased task dispatcher: handshake, config port, FIFO, control.
//
//   channel  direction  handshake                       payload
//   in       input      in_valid_i / in_stall_o         in_data_i  (bptd_pkg::in_item_t)
//   out      output     out_valid_o / out_stall_i       out_data_o (bptd_pkg::out_item_t)
//   config   input      psel/penable/pwrite/pready      paddr, pwdata, prdata
//
// One transaction per cycle when not stalled; each passes the input, then the result register.
// The head entry of the task store is read every cycle into a registered read port.
// Reset clears all control state and sets collect_ticks to 45; the store is not cleared.
// A stalled result holds one more transaction in the input register, then in_stall_o rises.
`include "batch_phased_task_dispatcher_assert.svh"

module batch_phased_task_dispatcher #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned MAX_WORKERS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bptd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bptd_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned BUSY_W = $clog2(MAX_WORKERS + 1);

  logic                in_valid_q;
  bptd_pkg::in_item_t  in_data_q;
  logic                out_valid_q;
  bptd_pkg::out_item_t out_data_q;
  logic                advance, accept, proc;
  logic [15:0]         collect_ticks_q;
  logic                cfg_wr;
  bptd_pkg::qop_t      qop;
  bptd_pkg::out_item_t result;
  logic [23:0]         head_data;
  logic [CNT_W-1:0]    q_count, q_count_next;
  logic [BUSY_W-1:0]   busy;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign proc       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= in_data_i;
    end
    if (proc) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == bptd_pkg::ADDR_COLLECT_TICKS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collect_ticks_q <= bptd_pkg::COLLECT_TICKS_RESET;
    end else if (cfg_wr) begin
      collect_ticks_q <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == bptd_pkg::ADDR_COLLECT_TICKS) ? {16'd0, collect_ticks_q} : '0;

  bptd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .qop_i        (qop),
    .wdata_i      ({in_data_q.task_id, in_data_q.task_duration}),
    .head_data_o  (head_data),
    .count_o      (q_count),
    .count_next_o (q_count_next)
  );

  bptd_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_WORKERS (MAX_WORKERS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (proc),
    .item_i          (in_data_q),
    .collect_ticks_i (collect_ticks_q),
    .count_i         (q_count),
    .count_next_i    (q_count_next),
    .head_data_i     (head_data),
    .qop_o           (qop),
    .busy_o          (busy),
    .result_o        (result)
  );

  `BPTD_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, q_count <= CNT_W'(QUEUE_DEPTH))
  `BPTD_ASSERT_ALWAYS(a_busy_bound, clk_i, rst_ni, busy <= BUSY_W'(MAX_WORKERS))
  `BPTD_ASSERT_NEXT(a_proc_to_out, clk_i, rst_ni, proc, out_valid_q)
  `BPTD_ASSERT_IMPLIES(a_dispatch_busy, clk_i, rst_ni, out_valid_q && (out_data_q.status == bptd_pkg::ST_DISPATCHED), out_data_q.active_count != 3'd0)

endmodule
